@@ src/mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh container decoder package
// Shared types and constants for the container parser and its top level.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // Parser phases, one-hot encoded.
  typedef enum logic [9:0] {
    PH_MAGIC    = 10'b00_0000_0001,
    PH_COUNT    = 10'b00_0000_0010,
    PH_NAMELEN  = 10'b00_0000_0100,
    PH_NAME     = 10'b00_0000_1000,
    PH_MATERIAL = 10'b00_0001_0000,
    PH_VCOUNT   = 10'b00_0010_0000,
    PH_VERT     = 10'b00_0100_0000,
    PH_ICOUNT   = 10'b00_1000_0000,
    PH_INDEX    = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  // Token kinds carried on the output.
  typedef enum logic [3:0] {
    TK_END       = 4'd0,
    TK_GROUPS    = 4'd1,
    TK_NAME_LEN  = 4'd2,
    TK_NAME_BYTE = 4'd3,
    TK_MATERIAL  = 4'd4,
    TK_VCOUNT    = 4'd5,
    TK_VERTEX    = 4'd6,
    TK_ICOUNT    = 4'd7,
    TK_INDEX     = 4'd8,
    TK_ERROR     = 4'd9
  } kind_t;

  // Stream status reported with each token.
  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_BAD_MAGIC = 2'd3
  } status_t;

  // One result token.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [3:0]  attr;
    logic [31:0] group;
    logic        eos;
    status_t     status;
  } token_t;

  localparam logic [7:0] MAGIC_0 = 8'h42;  // 'B'
  localparam logic [7:0] MAGIC_1 = 8'h4D;  // 'M'
  localparam logic [7:0] MAGIC_2 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_3 = 8'h31;  // '1'

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = MAGIC_0;
      2'd1:    b = MAGIC_1;
      2'd2:    b = MAGIC_2;
      default: b = MAGIC_3;
    endcase
    return b;
  endfunction

endpackage

@@ src/mcd_parser.sv @@
// ----------------------------------------------------------------------------
// Mesh container parser
// Holds the parse state and turns one byte into at most one token.
// ----------------------------------------------------------------------------
module mcd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,       // a byte transaction is accepted this cycle
  input  logic [7:0]    data_byte,
  input  logic          stream_last,
  output logic          tok_valid,
  output mcd_pkg::token_t tok
);

  mcd_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [23:0] word_assembler, word_assembler_next;
  logic [31:0] groups_total, groups_total_next;
  logic [31:0] group_counter, group_counter_next;
  logic [31:0] items_remaining, items_remaining_next;
  logic [3:0]  attribute_counter, attribute_counter_next;
  logic        failed, failed_next;

  logic [31:0] word;
  logic        word_done;
  logic [31:0] items_dec;
  logic [31:0] group_inc;
  logic        still_busy;

  assign word      = {data_byte, word_assembler};
  assign items_dec = items_remaining - 32'd1;
  assign group_inc = group_counter + 32'd1;

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    word_assembler_next    = word_assembler;
    groups_total_next      = groups_total;
    group_counter_next     = group_counter;
    items_remaining_next   = items_remaining;
    attribute_counter_next = attribute_counter;
    failed_next            = failed;
    word_done              = 1'b0;
    still_busy             = 1'b0;
    tok_valid              = 1'b0;
    tok.kind               = mcd_pkg::TK_END;
    tok.value              = '0;
    tok.attr               = '0;
    tok.group              = group_counter;
    tok.eos                = stream_last;
    tok.status             = mcd_pkg::ST_BUSY;

    if (!failed) begin
      case (phase)
        mcd_pkg::PH_MAGIC: begin
          if (data_byte != mcd_pkg::magic_byte(byte_position)) begin
            failed_next = 1'b1;
            tok_valid   = 1'b1;
            tok.kind    = mcd_pkg::TK_ERROR;
          end else if (byte_position == 2'd3) begin
            byte_position_next = 2'd0;
            phase_next         = mcd_pkg::PH_COUNT;
          end else begin
            byte_position_next = byte_position + 2'd1;
          end
        end
        mcd_pkg::PH_NAME: begin
          tok_valid            = 1'b1;
          tok.kind             = mcd_pkg::TK_NAME_BYTE;
          tok.value            = {24'd0, data_byte};
          items_remaining_next = items_dec;
          if (items_dec == 32'd0) begin
            phase_next = mcd_pkg::PH_MATERIAL;
          end
        end
        mcd_pkg::PH_COUNT, mcd_pkg::PH_NAMELEN, mcd_pkg::PH_MATERIAL,
        mcd_pkg::PH_VCOUNT, mcd_pkg::PH_VERT, mcd_pkg::PH_ICOUNT,
        mcd_pkg::PH_INDEX: begin
          if (byte_position != 2'd3) begin
            word_assembler_next = word_assembler |
                                  24'({16'd0, data_byte} << {byte_position, 3'b000});
            byte_position_next  = byte_position + 2'd1;
          end else begin
            word_assembler_next = '0;
            byte_position_next  = 2'd0;
            word_done           = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (word_done) begin
        tok_valid = 1'b1;
        tok.value = word;
        case (phase)
          mcd_pkg::PH_COUNT: begin
            tok.kind           = mcd_pkg::TK_GROUPS;
            tok.group          = '0;
            groups_total_next  = word;
            group_counter_next = '0;
            phase_next = (word == 32'd0) ? mcd_pkg::PH_DONE : mcd_pkg::PH_NAMELEN;
          end
          mcd_pkg::PH_NAMELEN: begin
            tok.kind             = mcd_pkg::TK_NAME_LEN;
            items_remaining_next = word;
            phase_next = (word == 32'd0) ? mcd_pkg::PH_MATERIAL : mcd_pkg::PH_NAME;
          end
          mcd_pkg::PH_MATERIAL: begin
            tok.kind   = mcd_pkg::TK_MATERIAL;
            phase_next = mcd_pkg::PH_VCOUNT;
          end
          mcd_pkg::PH_VCOUNT: begin
            tok.kind               = mcd_pkg::TK_VCOUNT;
            items_remaining_next   = word;
            attribute_counter_next = '0;
            phase_next = (word == 32'd0) ? mcd_pkg::PH_ICOUNT : mcd_pkg::PH_VERT;
          end
          mcd_pkg::PH_VERT: begin
            tok.kind               = mcd_pkg::TK_VERTEX;
            tok.attr               = attribute_counter;
            attribute_counter_next = attribute_counter + 4'd1;
            if (attribute_counter == 4'd15) begin
              items_remaining_next = items_dec;
              if (items_dec == 32'd0) begin
                phase_next = mcd_pkg::PH_ICOUNT;
              end
            end
          end
          mcd_pkg::PH_ICOUNT: begin
            tok.kind             = mcd_pkg::TK_ICOUNT;
            items_remaining_next = word;
            if (word == 32'd0) begin
              group_counter_next = group_inc;
              phase_next = (group_inc == groups_total) ? mcd_pkg::PH_DONE
                                                       : mcd_pkg::PH_NAMELEN;
            end else begin
              phase_next = mcd_pkg::PH_INDEX;
            end
          end
          default: begin
            tok.kind             = mcd_pkg::TK_INDEX;
            items_remaining_next = items_dec;
            if (items_dec == 32'd0) begin
              group_counter_next = group_inc;
              phase_next = (group_inc == groups_total) ? mcd_pkg::PH_DONE
                                                       : mcd_pkg::PH_NAMELEN;
            end
          end
        endcase
      end

      if (failed_next) begin
        tok.status = mcd_pkg::ST_BAD_MAGIC;
      end

      if (stream_last) begin
        // The closing byte always produces a token, end-only if nothing else.
        tok_valid  = 1'b1;
        still_busy = phase_next == mcd_pkg::PH_MAGIC   ||
                     phase_next == mcd_pkg::PH_COUNT   ||
                     phase_next == mcd_pkg::PH_NAMELEN ||
                     phase_next == mcd_pkg::PH_NAME    ||
                     phase_next == mcd_pkg::PH_MATERIAL||
                     phase_next == mcd_pkg::PH_VCOUNT  ||
                     phase_next == mcd_pkg::PH_VERT    ||
                     phase_next == mcd_pkg::PH_ICOUNT  ||
                     phase_next == mcd_pkg::PH_INDEX;
        if (!failed_next) begin
          tok.status = still_busy ? mcd_pkg::ST_TRUNCATED : mcd_pkg::ST_COMPLETE;
        end
      end
    end

    // The closing byte returns the parser to its reset state.
    if (stream_last) begin
      phase_next             = mcd_pkg::PH_MAGIC;
      byte_position_next     = '0;
      word_assembler_next    = '0;
      groups_total_next      = '0;
      group_counter_next     = '0;
      items_remaining_next   = '0;
      attribute_counter_next = '0;
      failed_next            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= mcd_pkg::PH_MAGIC;
      byte_position     <= '0;
      word_assembler    <= '0;
      groups_total      <= '0;
      group_counter     <= '0;
      items_remaining   <= '0;
      attribute_counter <= '0;
      failed            <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      word_assembler    <= word_assembler_next;
      groups_total      <= groups_total_next;
      group_counter     <= group_counter_next;
      items_remaining   <= items_remaining_next;
      attribute_counter <= attribute_counter_next;
      failed            <= failed_next;
    end
  end

endmodule

@@ src/mesh_container_decoder.sv @@
// ----------------------------------------------------------------------------
// Mesh container decoder
// Byte-stream parser for BMD1 mesh containers that emits one token per field word and per name byte.
// ----------------------------------------------------------------------------
// The decoder takes one container byte per transaction on the slave stream and
// sustains one byte per clock cycle: the parse state is updated by short
// combinational logic per byte, and the token is loaded into the output
// register by the same clock edge that accepts the byte, so it is offered on
// the master side from the next cycle. The input is stalled only while the
// output register holds a token that the master side has not yet taken. A
// token is produced for every completed little-endian 32-bit word after the
// magic up to the end of the last group, and every name byte; unless the magic
// failed, the s_tlast byte closes the stream with a token (end-only if nothing
// else) whose status tells complete or truncated, after which the decoder is
// ready for the next container. A wrong magic byte yields an error token, and
// every later byte of that container, including the last, is dropped silently.
// ----------------------------------------------------------------------------
module mesh_container_decoder (
  input  logic        clk,
  input  logic        rst,
  // Slave stream: one container byte per transaction.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // stream_last
  // Master stream: one token per transaction.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] token_value, [35:32] vertex_attribute,
                                 // [67:36] group_number, [69:68] stream_status,
                                 // [71:70] zero
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // end_of_stream
);

  logic            take;
  logic            tok_valid;
  mcd_pkg::token_t tok;
  mcd_pkg::token_t out_tok;
  logic            out_valid;

  // A byte is taken whenever the output register is empty or is being drained
  // in the same cycle, so a stalled token does not hold up the parser longer
  // than needed.
  assign s_tready = !out_valid || m_tready;
  assign take     = s_tvalid && s_tready;

  mcd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (s_tdata),
    .stream_last (s_tlast),
    .tok_valid   (tok_valid),
    .tok         (tok)
  );

  // Output register: loaded on each accepted byte that yields a token,
  // cleared when its token is taken with nothing new behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= tok_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok_valid) begin
      out_tok <= tok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_tok.kind;
  assign m_tlast  = out_tok.eos;
  assign m_tdata  = {2'b00, out_tok.status, out_tok.group, out_tok.attr, out_tok.value};

  // A closing token always carries a final status.
  a_eos_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[69:68] != mcd_pkg::ST_BUSY)
    else $error("closing token without final status");

  // An error token always reports bad magic.
  a_error_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mcd_pkg::TK_ERROR |-> m_tdata[69:68] == mcd_pkg::ST_BAD_MAGIC)
    else $error("error token with wrong status");

  // Only vertex words carry a nonzero attribute number.
  a_attr_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35:32] != 4'd0 |-> m_tuser == mcd_pkg::TK_VERTEX)
    else $error("attribute on non-vertex token");

  // A token waiting at the output blocks the input until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted over a stalled token");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mesh container decoder testbench
// Streams whole, cut short, corrupted and padded containers into the decoder
// with random gaps on the input and random stalls on the output. A byte-level
// model of the parser predicts every token, and each token taken from the
// decoder is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  // Magic sequence, first byte in the lowest bits.
  localparam logic [31:0] BMD_MAGIC = {8'h31, 8'h44, 8'h4D, 8'h42};
  // The random part stops once this many bytes have gone in.
  localparam int unsigned RUN_BYTES = 1600;
  // Past this byte count the run is free of gaps and stalls.
  localparam int unsigned CALM_BYTES = 1300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [71:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  always #5 clk = ~clk;

  mesh_container_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Our own copy of the parser state.
  mcd_pkg::phase_t phase;
  logic [1:0]  byte_pos;
  logic [23:0] partial_word;
  logic [31:0] groups_total;
  logic [31:0] group_idx;
  logic [31:0] items_left;
  logic [3:0]  attr_idx;
  logic        dropped;

  mcd_pkg::token_t pending_tokens[$];  // predicted tokens not yet seen on the output
  logic [7:0]  container[$];       // bytes of the container being built
  bit          idle_on = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned err_cnt = 0;
  int          stall_left = 0;
  mcd_pkg::token_t want;

  task automatic clear_decoder();
    phase        = mcd_pkg::PH_MAGIC;
    byte_pos     = 2'd0;
    partial_word = 24'd0;
    groups_total = 32'd0;
    group_idx    = 32'd0;
    items_left   = 32'd0;
    attr_idx     = 4'd0;
    dropped      = 1'b0;
  endtask

  task automatic close_group();
    group_idx = group_idx + 32'd1;
    phase = (group_idx == groups_total) ? mcd_pkg::PH_DONE : mcd_pkg::PH_NAMELEN;
  endtask

  // Advances the parser copy by one accepted byte and queues the token it
  // produces, if any.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    mcd_pkg::token_t t;
    logic        have;
    logic        word_done;
    logic [31:0] word;
    t         = '0;
    t.kind    = mcd_pkg::TK_END;
    t.status  = mcd_pkg::ST_BUSY;
    t.group   = group_idx;
    have      = 1'b0;
    word_done = 1'b0;
    word      = 32'd0;
    // After a bad magic byte everything up to the end of the container is
    // swallowed without a token.
    if (dropped) begin
      if (last) clear_decoder();
      return;
    end
    if (phase == mcd_pkg::PH_MAGIC) begin
      if (b != BMD_MAGIC[8*byte_pos +: 8]) begin
        dropped = 1'b1;
        have    = 1'b1;
        t.kind  = mcd_pkg::TK_ERROR;
      end else if (byte_pos == 2'd3) begin
        byte_pos = 2'd0;
        phase    = mcd_pkg::PH_COUNT;
      end else begin
        byte_pos = byte_pos + 2'd1;
      end
    end else if (phase == mcd_pkg::PH_NAME) begin
      have       = 1'b1;
      t.kind     = mcd_pkg::TK_NAME_BYTE;
      t.value    = {24'd0, b};
      items_left = items_left - 32'd1;
      if (items_left == 32'd0) phase = mcd_pkg::PH_MATERIAL;
    end else if (phase != mcd_pkg::PH_DONE) begin
      // Words arrive little-endian; the fourth byte completes one.
      if (byte_pos != 2'd3) begin
        partial_word[8*byte_pos +: 8] = b;
        byte_pos = byte_pos + 2'd1;
      end else begin
        word         = {b, partial_word};
        partial_word = 24'd0;
        byte_pos     = 2'd0;
        word_done    = 1'b1;
      end
    end
    if (word_done) begin
      have    = 1'b1;
      t.value = word;
      case (phase)
        mcd_pkg::PH_COUNT: begin
          t.kind       = mcd_pkg::TK_GROUPS;
          t.group      = 32'd0;
          groups_total = word;
          group_idx    = 32'd0;
          phase        = (word == 32'd0) ? mcd_pkg::PH_DONE : mcd_pkg::PH_NAMELEN;
        end
        mcd_pkg::PH_NAMELEN: begin
          t.kind     = mcd_pkg::TK_NAME_LEN;
          items_left = word;
          phase      = (word == 32'd0) ? mcd_pkg::PH_MATERIAL : mcd_pkg::PH_NAME;
        end
        mcd_pkg::PH_MATERIAL: begin
          t.kind = mcd_pkg::TK_MATERIAL;
          phase  = mcd_pkg::PH_VCOUNT;
        end
        mcd_pkg::PH_VCOUNT: begin
          t.kind     = mcd_pkg::TK_VCOUNT;
          items_left = word;
          attr_idx   = 4'd0;
          phase      = (word == 32'd0) ? mcd_pkg::PH_ICOUNT : mcd_pkg::PH_VERT;
        end
        mcd_pkg::PH_VERT: begin
          t.kind   = mcd_pkg::TK_VERTEX;
          t.attr   = attr_idx;
          attr_idx = attr_idx + 4'd1;
          // The sixteenth word closes one vertex.
          if (t.attr == 4'd15) begin
            items_left = items_left - 32'd1;
            if (items_left == 32'd0) phase = mcd_pkg::PH_ICOUNT;
          end
        end
        mcd_pkg::PH_ICOUNT: begin
          t.kind     = mcd_pkg::TK_ICOUNT;
          items_left = word;
          if (word == 32'd0) close_group();
          else phase = mcd_pkg::PH_INDEX;
        end
        default: begin
          t.kind     = mcd_pkg::TK_INDEX;
          items_left = items_left - 32'd1;
          if (items_left == 32'd0) close_group();
        end
      endcase
    end
    if (dropped) t.status = mcd_pkg::ST_BAD_MAGIC;
    // The last byte always closes the stream, with an end-only token when it
    // completes nothing else.
    if (last) begin
      have  = 1'b1;
      t.eos = 1'b1;
      if (!dropped) begin
        t.status = (phase == mcd_pkg::PH_DONE) ? mcd_pkg::ST_COMPLETE
                                               : mcd_pkg::ST_TRUNCATED;
      end
    end
    if (have) pending_tokens.insert(pending_tokens.size(), t);
    if (last) clear_decoder();
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_word(input logic [31:0] w);
    container.insert(container.size(), w[7:0]);
    container.insert(container.size(), w[15:8]);
    container.insert(container.size(), w[23:16]);
    container.insert(container.size(), w[31:24]);
  endtask

  // One group with random name, material, vertex and index content.
  task automatic put_group(input int name_len, input int n_vert, input int n_idx);
    put_word(name_len);
    repeat (name_len) container.insert(container.size(), rand_byte());
    put_word(rand_word());
    put_word(n_vert);
    repeat (16 * n_vert) put_word(rand_word());
    put_word(n_idx);
    repeat (n_idx) put_word(rand_word());
  endtask

  // A well-formed container with up to max_groups small groups. Vertices are
  // long, so only about one group in four carries one.
  task automatic build_container(input int max_groups);
    int n_groups;
    container.delete();
    put_word(BMD_MAGIC);
    n_groups = $urandom_range(0, max_groups);
    put_word(n_groups);
    repeat (n_groups)
      put_group($urandom_range(0, 4), ($urandom_range(0, 3) == 0) ? 1 : 0,
                $urandom_range(0, 4));
  endtask

  // Presents one byte and holds it until the decoder takes it. Between bytes
  // the valid may drop for a short burst.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_container();
    foreach (container[i]) send_byte(container[i], i == container.size() - 1);
  endtask

  task automatic trim_container(input int keep);
    while (container.size() > keep) void'(container.pop_back());
  endtask

  // A wrong byte at each magic position, a wrong byte that is also the last,
  // and a stream that ends inside a correct magic.
  task automatic test_bad_magic();
    for (int p = 0; p < 4; p++) begin
      build_container(1);
      container[p] = container[p] ^ 8'($urandom_range(1, 255));
      send_container();
    end
    container.delete();
    container.insert(container.size(), 8'h00);
    send_container();
    container.delete();
    container.insert(container.size(), BMD_MAGIC[7:0]);
    container.insert(container.size(), BMD_MAGIC[15:8]);
    send_container();
  endtask

  // A zero group count, and a group whose name, vertices and indices are
  // all empty.
  task automatic test_zero_counts();
    container.delete();
    put_word(BMD_MAGIC);
    put_word(32'd0);
    send_container();
    container.delete();
    put_word(BMD_MAGIC);
    put_word(32'd1);
    put_group(0, 0, 0);
    send_container();
  endtask

  // Full-width words, two vertices so the attribute number wraps, and a
  // group count of all ones that can never be finished.
  task automatic test_extremes();
    container.delete();
    put_word(BMD_MAGIC);
    put_word(32'd2);
    put_word(32'd2);
    container.insert(container.size(), 8'h00);
    container.insert(container.size(), 8'hFF);
    put_word(32'hFFFF_FFFF);
    put_word(32'd2);
    repeat (16) put_word(32'hFFFF_FFFF);
    repeat (16) put_word(32'h0000_0000);
    put_word(32'd1);
    put_word(32'hFFFF_FFFF);
    put_group(1, 0, 1);
    send_container();
    container.delete();
    put_word(BMD_MAGIC);
    put_word(32'hFFFF_FFFF);
    put_group(1, 0, 1);
    send_container();
  endtask

  // The same one-group layout cut off inside the count word, on a name byte,
  // on the byte that finishes a vertex word, and inside the indices.
  task automatic test_truncation();
    int cuts[4];
    cuts = '{6, 14, 27, 95};
    foreach (cuts[i]) begin
      container.delete();
      put_word(BMD_MAGIC);
      put_word(32'd1);
      put_group(3, 1, 2);
      trim_container(cuts[i]);
      send_container();
    end
  endtask

  // Bytes after the final group give only the closing end-only token.
  task automatic test_trailing();
    build_container(2);
    repeat ($urandom_range(1, 5)) container.insert(container.size(), rand_byte());
    send_container();
  endtask

  // The input halts mid-container until every predicted token has come out,
  // then the container is finished.
  task automatic test_drain_pause();
    int half;
    container.delete();
    put_word(BMD_MAGIC);
    put_word(32'd2);
    put_group(2, 0, 3);
    put_group(1, 0, 2);
    half = container.size() / 2;
    for (int i = 0; i < half; i++) send_byte(container[i], 1'b0);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
    for (int i = half; i < container.size(); i++)
      send_byte(container[i], i == container.size() - 1);
  endtask

  // Mostly well-formed containers with random content, mixed with early ends,
  // corrupted magic, pure noise, padding and impossible group counts.
  task automatic test_random();
    int pick;
    while (bytes_sent < RUN_BYTES) begin
      idle_on = (bytes_sent < CALM_BYTES) && ($urandom_range(0, 3) != 0);
      build_container(3);
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1, 2: trim_container($urandom_range(1, container.size() - 1));
        3, 4: begin
          pick = $urandom_range(0, 3);
          container[pick] = container[pick] ^ 8'($urandom_range(1, 255));
        end
        5: begin
          container.delete();
          repeat ($urandom_range(1, 12)) container.insert(container.size(), 8'($urandom));
        end
        6, 7: repeat ($urandom_range(1, 6)) container.insert(container.size(), rand_byte());
        8: begin
          // Group count far larger than what follows.
          container[7] = 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
      send_container();
    end
    idle_on = 1'b0;
  endtask

  // Output side: ready drops in random bursts while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 3);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s differs: expected %h, actual %h", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Every token taken from the decoder is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d value %h", m_tuser, m_tdata[31:0]);
        err_cnt++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind",       32'(want.kind),   32'(m_tuser));
        check_field("token_value",      want.value,       m_tdata[31:0]);
        check_field("vertex_attribute", 32'(want.attr),   32'(m_tdata[35:32]));
        check_field("group_number",     want.group,       m_tdata[67:36]);
        check_field("stream_status",    32'(want.status), 32'(m_tdata[69:68]));
        check_field("end_of_stream",    32'(want.eos),    32'(m_tlast));
      end
    end
  end

  initial begin
    clear_decoder();
    repeat (10) @(posedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;
    test_bad_magic();
    test_zero_counts();
    test_extremes();
    test_truncation();
    test_trailing();
    test_drain_pause();
    test_random();
    s_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
